/* hw/rtl/hrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned IN_WIDTH        = 64;

  // largest count widths over the whole parameter range (up to 64 bits)
  localparam int unsigned DIGITS_W   = 5;
  localparam int unsigned DEC_DIST_W = 4;
  localparam int unsigned HEX_DIST_W = 5;
  localparam int unsigned PROD_W     = 11;

  localparam int unsigned SMALL_LIMIT = 16;
  localparam int unsigned POW2_FLOOR  = 64;
  localparam int unsigned HEX_WEIGHT  = 5;
  localparam int unsigned DEC_WEIGHT  = 6;

  typedef struct packed {
    logic [DIGITS_W-1:0]   dec_digits;
    logic [DEC_DIST_W-1:0] dec_distinct;
    logic [DIGITS_W-1:0]   hex_digits;
    logic [HEX_DIST_W-1:0] hex_distinct;
  } counts_t;

endpackage

`default_nettype wire

/* hw/rtl/hex_or_decimal_radix_choice.sv */
`timescale 1ns / 1ps
`default_nettype none

// Decides whether an unsigned constant reads better in hex (use_hex = 1) or
// decimal; only the low VALUE_WIDTH bits of value are looked at. Values below
// 16 give decimal, single-bit values above 64 give hex, and every other value
// goes through a digit test: hex wins when
// 5 * decimal distinct digits * hex digits >= 6 * hex distinct digits * decimal digits.
// The decimal digits come from a row of BCD shift-and-add-three cells that
// takes one bit of the value per cycle. An accepted item passes through
// the shift state, which moves its bits through the cell row, the tally
// state, which counts the digits, and the decide state, which forms the
// decision into the output register. One item is worked on at a time; the
// next one is taken as soon as the result sits in the output register, even
// if that result has not yet been taken.
module hex_or_decimal_radix_choice #(
  parameter int unsigned VALUE_WIDTH = hrc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [hrc_pkg::IN_WIDTH-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              use_hex
);

  import hrc_pkg::*;

  localparam int unsigned NDEC  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned NHEX  = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SHIFT  = 4'b0010,
    ST_TALLY  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [CNT_W-1:0]        cnt;
  logic [VALUE_WIDTH-1:0]  masked;
  logic [VALUE_WIDTH-1:0]  orig;
  logic [VALUE_WIDTH-1:0]  sh;
  logic                    is_small;
  logic                    is_pow2;
  logic                    accept;
  logic                    out_free;
  logic [NDEC:0]           carry;
  logic [NDEC*4-1:0]       dec;
  logic [NHEX*4-1:0]       hex;
  counts_t                 counts;
  logic [PROD_W-1:0]       lhs;
  logic [PROD_W-1:0]       rhs;
  logic                    decision;

  assign masked   = value[VALUE_WIDTH-1:0];
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SHIFT;
      ST_SHIFT:  if (cnt == CNT_W'(VALUE_WIDTH - 1)) state_next = ST_TALLY;
      ST_TALLY:  state_next = ST_DECIDE;
      ST_DECIDE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt      <= '0;
      sh       <= masked;
      orig     <= masked;
      is_small <= (masked < VALUE_WIDTH'(SMALL_LIMIT));
      is_pow2  <= (masked > VALUE_WIDTH'(POW2_FLOOR)) &&
                  ((masked & (masked - VALUE_WIDTH'(1))) == '0);
    end else if (state == ST_SHIFT) begin
      cnt <= cnt + CNT_W'(1);
      sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  // bits enter the least significant cell, msb first
  assign carry[0] = sh[VALUE_WIDTH-1];

  for (genvar i = 0; i < NDEC; i++) begin : g_cell
    hrc_cell u_cell (
      .clk       (clk),
      .clear     (accept),
      .shift     (state == ST_SHIFT),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .digit     (dec[i*4 +: 4])
    );
  end

  assign hex = (NHEX * 4)'(orig);

  hrc_tally #(
    .NDEC (NDEC),
    .NHEX (NHEX)
  ) u_tally (
    .clk    (clk),
    .load   (state == ST_TALLY),
    .dec    (dec),
    .hex    (hex),
    .counts (counts)
  );

  assign lhs = PROD_W'(HEX_WEIGHT) * PROD_W'(counts.dec_distinct) * PROD_W'(counts.hex_digits);
  assign rhs = PROD_W'(DEC_WEIGHT) * PROD_W'(counts.hex_distinct) * PROD_W'(counts.dec_digits);

  always_comb begin
    priority if (is_small) begin
      decision = 1'b0;
    end else if (is_pow2) begin
      decision = 1'b1;
    end else begin
      decision = (lhs >= rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DECIDE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && out_free) begin
      use_hex <= decision;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hrc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrc_cell (
  input  wire logic       clk,
  input  wire logic       clear,
  input  wire logic       shift,
  input  wire logic       carry_in,
  output logic            carry_out,
  output logic [3:0]      digit
);

  logic [3:0] adjusted;

  // add three before the shift so the digit carries correctly into the next cell
  assign adjusted  = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adjusted[3];

  always_ff @(posedge clk) begin
    if (clear) begin
      digit <= 4'd0;
    end else if (shift) begin
      digit <= {adjusted[2:0], carry_in};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hrc_tally.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrc_tally #(
  parameter int unsigned NDEC = 20,
  parameter int unsigned NHEX = 16
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic [NDEC*4-1:0]    dec,
  input  wire logic [NHEX*4-1:0]    hex,
  output hrc_pkg::counts_t          counts
);

  import hrc_pkg::*;

  logic [9:0]            dec_seen;
  logic [15:0]           hex_seen;
  logic [DIGITS_W-1:0]   dec_n;
  logic [DIGITS_W-1:0]   hex_n;
  logic [DEC_DIST_W-1:0] dec_u;
  logic [HEX_DIST_W-1:0] hex_u;
  counts_t               counts_next;

  always_comb begin
    dec_seen = '0;
    dec_n    = DIGITS_W'(1);
    for (int i = 0; i < NDEC; i++) begin
      if (dec[i*4 +: 4] != 4'd0) begin
        dec_n = DIGITS_W'(i + 1);
      end
    end
    // only digits up to the leading one count as significant
    for (int i = 0; i < NDEC; i++) begin
      if (DIGITS_W'(i) < dec_n) begin
        dec_seen[dec[i*4 +: 4]] = 1'b1;
      end
    end
    dec_u = '0;
    for (int i = 0; i < 10; i++) begin
      dec_u = dec_u + DEC_DIST_W'(dec_seen[i]);
    end
  end

  always_comb begin
    hex_seen = '0;
    hex_n    = DIGITS_W'(1);
    for (int i = 0; i < NHEX; i++) begin
      if (hex[i*4 +: 4] != 4'd0) begin
        hex_n = DIGITS_W'(i + 1);
      end
    end
    for (int i = 0; i < NHEX; i++) begin
      if (DIGITS_W'(i) < hex_n) begin
        hex_seen[hex[i*4 +: 4]] = 1'b1;
      end
    end
    hex_u = '0;
    for (int i = 0; i < 16; i++) begin
      hex_u = hex_u + HEX_DIST_W'(hex_seen[i]);
    end
  end

  always_comb begin
    counts_next.dec_digits   = dec_n;
    counts_next.dec_distinct = dec_u;
    counts_next.hex_digits   = hex_n;
    counts_next.hex_distinct = hex_u;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      counts <= counts_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hrc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [hrc_pkg::IN_WIDTH-1:0] value,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         use_hex
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(use_hex))
    else $error("stalled result changed");

  // one item at a time: busy straight after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while busy");

  // an item must first pass through the digit row, so no result can follow it at once
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind hex_or_decimal_radix_choice hrc_checker u_hrc_checker (.*);

`default_nettype wire

/* tb/hex_or_decimal_radix_choice_tb.sv */
`timescale 1ns / 1ps

module hex_or_decimal_radix_choice_tb;
  import hrc_pkg::*;

  localparam int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = VALUE_WIDTH + 20;

  class radix_scoreboard;
    bit expected_q[$];
    int unsigned mismatches;

    // lhs/rhs are the two sides of the digit test, zero when it is skipped
    function bit decide(input logic [IN_WIDTH-1:0] raw, output int unsigned lhs,
                        output int unsigned rhs);
      logic [63:0] mask;
      logic [63:0] v;
      logic [63:0] r;
      logic [15:0] dec_seen;
      logic [15:0] hex_seen;
      int unsigned dec_n;
      int unsigned hex_n;
      int unsigned d;
      mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      v = raw & mask;
      lhs = 0;
      rhs = 0;
      if (v < SMALL_LIMIT) return 1'b0;
      if (v > POW2_FLOOR && (v & (v - 64'd1)) == 64'd0) return 1'b1;
      dec_seen = '0;
      hex_seen = '0;
      dec_n = 0;
      hex_n = 0;
      r = v;
      do begin
        d = int'(r % 64'd10);
        dec_seen[d] = 1'b1;
        r = r / 64'd10;
        dec_n++;
      end while (r != 64'd0);
      r = v;
      do begin
        d = int'(r[3:0]);
        hex_seen[d] = 1'b1;
        r = r >> 4;
        hex_n++;
      end while (r != 64'd0);
      lhs = HEX_WEIGHT * $countones(dec_seen) * hex_n;
      rhs = DEC_WEIGHT * $countones(hex_seen) * dec_n;
      return lhs >= rhs;
    endfunction

    function void note_value(input logic [IN_WIDTH-1:0] v);
      int unsigned l;
      int unsigned r;
      expected_q.push_back(decide(v, l, r));
    endfunction

    function void check_result(input logic got);
      bit want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: use_hex=%b", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("use_hex mismatch: expected %b, got %b", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [IN_WIDTH-1:0] value;
  logic out_valid;
  logic out_stall;
  logic use_hex;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;
  radix_scoreboard sb;

  hex_or_decimal_radix_choice #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .use_hex(use_hex)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hex_or_decimal_radix_choice_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(use_hex);
      if (in_valid && !in_stall) sb.note_value(value);
    end
  end

  task send_value(input logic [IN_WIDTH-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [IN_WIDTH-1:0] random_value();
    logic [63:0] v;
    int unsigned kind;
    int unsigned len;
    int unsigned a;
    int unsigned b;
    kind = $urandom_range(99);
    v = {$urandom, $urandom};
    if (kind < 10) begin
      v = 64'($urandom_range(SMALL_LIMIT - 1));
    end else if (kind < 20) begin
      v = 64'd1 << $urandom_range(63);
    end else if (kind < 28) begin
      // just either side of a single set bit
      v = (64'd1 << $urandom_range(63)) + 64'($urandom_range(4)) - 64'd2;
    end else if (kind < 38) begin
      // decimal digits drawn from two values
      a = $urandom_range(9);
      b = $urandom_range(9);
      len = $urandom_range(19, 1);
      v = 64'd0;
      repeat (len) v = v * 64'd10 + 64'($urandom_range(1) ? a : b);
    end else if (kind < 48) begin
      a = $urandom_range(15);
      b = $urandom_range(15);
      len = $urandom_range(16, 1);
      v = 64'd0;
      repeat (len) v = (v << 4) | 64'($urandom_range(1) ? a : b);
    end else if (kind < 75) begin
      v = v >> $urandom_range(63);
    end
    return v;
  endfunction

  initial begin
    logic [IN_WIDTH-1:0] directed[$];
    logic [IN_WIDTH-1:0] cand;
    int unsigned lhs;
    int unsigned rhs;
    int unsigned ties;
    int unsigned tries;

    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    out_stall = 1'b0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sb = new();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    directed = '{64'd0, 64'd1, 64'd15, 64'd16, 64'd17, 64'd32, 64'd64, 64'd65, 64'd128,
                 64'd255, 64'd100, 64'd1000, 64'd999999, 64'hFFFF, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'h8000_0000_0000_0001, 64'h1234_5678_9ABC_DEF0,
                 64'd10000000000000000000};

    // ratio exactly on the 6/5 boundary, which must give hex
    ties = 0;
    tries = 0;
    while (ties < 3 && tries < 200000) begin
      cand = 64'($urandom_range(9999999, 1048576));
      void'(sb.decide(cand, lhs, rhs));
      if (lhs != 0 && lhs == rhs) begin
        directed.push_back(cand);
        ties++;
      end
      tries++;
    end

    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i / (RANDOM_ITEMS / 4))
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      send_value(random_value());
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("hex_or_decimal_radix_choice_tb passed");
    end else begin
      $display("hex_or_decimal_radix_choice_tb failed");
    end
    $finish;
  end

endmodule
